@@ hdl/hsv_window_pixel_mask_core_macros.svh @@
// Assertion macros shared by the HSV window pixel mask RTL.
`ifndef HSV_WINDOW_PIXEL_MASK_CORE_MACROS_SVH
`define HSV_WINDOW_PIXEL_MASK_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HWPM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hwpm: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define HWPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hwpm: next-cycle check failed");

`endif

@@ hdl/hwpm_pkg.sv @@
// Types and constants of the HSV window pixel mask.
package hwpm_pkg;

   localparam int PIX_W   = 8;
   localparam int HUE_W   = 9;
   localparam int CSR_W   = 9;
   localparam int DIV_DW  = 8;
   localparam int DIV_QW  = 8;

   localparam logic [CSR_W-1:0] HUE_LOW_RST  = 9'd0;
   localparam logic [CSR_W-1:0] HUE_HIGH_RST = 9'd30;
   localparam logic [CSR_W-1:0] SAT_LOW_RST  = 9'd60;
   localparam logic [CSR_W-1:0] SAT_HIGH_RST = 9'd250;
   localparam logic [CSR_W-1:0] VAL_LOW_RST  = 9'd100;
   localparam logic [CSR_W-1:0] VAL_HIGH_RST = 9'd220;

   localparam logic [10:0] HUE_OFS_RED   = 11'd0;
   localparam logic [10:0] HUE_OFS_GREEN = 11'd120;
   localparam logic [10:0] HUE_OFS_BLUE  = 11'd240;
   localparam logic [10:0] HUE_FULL      = 11'd360;

   typedef enum logic [2:0] {
      CSR_HUE_LOW  = 3'd0,
      CSR_HUE_HIGH = 3'd1,
      CSR_SAT_LOW  = 3'd2,
      CSR_SAT_HIGH = 3'd3,
      CSR_VAL_LOW  = 3'd4,
      CSR_VAL_HIGH = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } hue_sector_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_in;
      logic [PIX_W-1:0] green_in;
      logic [PIX_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_out;
      logic [PIX_W-1:0] green_out;
      logic [PIX_W-1:0] blue_out;
      logic             in_region;
      logic [HUE_W-1:0] hue;
      logic [PIX_W-1:0] saturation;
      logic [PIX_W-1:0] brightness;
   } rsp_type;

   // Context that rides along the hue divider.
   typedef struct packed {
      req_type          pixel;
      logic [PIX_W-1:0] max_val;
      hue_sector_type   sector;
      logic             neg;
      logic             grey;
   } hue_side_type;

endpackage

@@ hdl/hsv_window_pixel_mask_core.sv @@
// Top level of the HSV window pixel mask: RGB to HSV, window test, pixel gate.
//
// One RGB pixel enters per clock and one result leaves per clock. A request
// is taken on any rising edge with start high and busy low; busy is high
// only during reset. The pipeline has no back-pressure: each result is
// shown on rsp_data for exactly one cycle, marked by rsp_valid, and the
// receiver must take it then. The pipeline is made of the two 8-stage
// pipelined dividers (hue and saturation) that run side by side, plus one
// stage each for input capture, max/min, scaling, hue/sat assembly and the
// window compare. The six window registers are written through the csr_
// channel, which is always ready; write them only while no pixel is in
// flight, since the compare stage reads them live. Indices above the
// register list are ignored. Windows are open: a component passes only
// when strictly above its low bound and strictly below its high bound.
// A grey pixel reports hue 0 and a black pixel reports saturation 0.
module hsv_window_pixel_mask_core
   import hwpm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_pixel,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [CSR_W-1:0] csr_data
);

`include "hsv_window_pixel_mask_core_macros.svh"

   localparam int NUM_W = DIV_DW + DIV_QW;
   localparam int HSW   = $bits(hue_side_type);

   // ------------------------------------------------------------------
   // Window registers
   // ------------------------------------------------------------------
   logic [CSR_W-1:0] hue_low_ff, hue_high_ff, sat_low_ff, sat_high_ff;
   logic [CSR_W-1:0] val_low_ff, val_high_ff;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_low_ff  <= HUE_LOW_RST;
         hue_high_ff <= HUE_HIGH_RST;
         sat_low_ff  <= SAT_LOW_RST;
         sat_high_ff <= SAT_HIGH_RST;
         val_low_ff  <= VAL_LOW_RST;
         val_high_ff <= VAL_HIGH_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HUE_LOW:  hue_low_ff  <= csr_data;
            CSR_HUE_HIGH: hue_high_ff <= csr_data;
            CSR_SAT_LOW:  sat_low_ff  <= csr_data;
            CSR_SAT_HIGH: sat_high_ff <= csr_data;
            CSR_VAL_LOW:  val_low_ff  <= csr_data;
            CSR_VAL_HIGH: val_high_ff <= csr_data;
            default: ;  // out of range: drop the write
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: capture the request
   // ------------------------------------------------------------------
   logic    p1_valid_ff;
   req_type p1_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      p1_pix_ff <= req_pixel;
   end

   // ------------------------------------------------------------------
   // Stage 2: max, min, sector and signed hue numerator
   // ------------------------------------------------------------------
   logic             p2_valid_ff;
   hue_side_type     p2_side_ff,  p2_side_in;
   logic [PIX_W-1:0] p2_mag_ff,   p2_mag_in;
   logic [PIX_W-1:0] p2_diff_ff,  p2_diff_in;

   always_comb begin
      logic [PIX_W-1:0] r, g, b, mx, mn, pa, pb;
      r = p1_pix_ff.red_in;
      g = p1_pix_ff.green_in;
      b = p1_pix_ff.blue_in;
      // Ties go to red first, then green.
      if (r >= g && r >= b) begin
         mx = r;
         pa = g;
         pb = b;
         p2_side_in.sector = SECTOR_RED;
      end else if (g >= b) begin
         mx = g;
         pa = b;
         pb = r;
         p2_side_in.sector = SECTOR_GREEN;
      end else begin
         mx = b;
         pa = r;
         pb = g;
         p2_side_in.sector = SECTOR_BLUE;
      end
      mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
      p2_side_in.pixel   = p1_pix_ff;
      p2_side_in.max_val = mx;
      p2_side_in.neg     = (pa < pb);
      p2_side_in.grey    = (mx == mn);
      p2_mag_in          = (pa < pb) ? (pb - pa) : (pa - pb);
      p2_diff_in         = mx - mn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p2_side_ff <= p2_side_in;
      p2_mag_ff  <= p2_mag_in;
      p2_diff_ff <= p2_diff_in;
   end

   // ------------------------------------------------------------------
   // Stage 3: scale numerators (60 * |n| and 255 * diff)
   // ------------------------------------------------------------------
   logic             p3_valid_ff;
   hue_side_type     p3_side_ff;
   logic [NUM_W-1:0] p3_hnum_ff, p3_hnum_in;
   logic [NUM_W-1:0] p3_snum_ff, p3_snum_in;
   logic [PIX_W-1:0] p3_diff_ff;

   always_comb begin
      logic [NUM_W-1:0] mag_x, diff_x;
      mag_x      = NUM_W'(p2_mag_ff);
      diff_x     = NUM_W'(p2_diff_ff);
      p3_hnum_in = (mag_x << 6) - (mag_x << 2);
      p3_snum_in = (diff_x << 8) - diff_x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p3_side_ff <= p2_side_ff;
      p3_hnum_ff <= p3_hnum_in;
      p3_snum_ff <= p3_snum_in;
      p3_diff_ff <= p2_diff_ff;
   end

   // ------------------------------------------------------------------
   // Stages 4..11: hue and saturation dividers in lockstep
   // ------------------------------------------------------------------
   logic              hue_dv_valid, sat_dv_valid;
   logic [DIV_QW-1:0] hue_q, sat_q;
   logic [HSW-1:0]    hue_side_bits;
   logic [0:0]        sat_side_bits;
   hue_side_type      dv_side;

   hwpm_div #(
      .DW (DIV_DW),
      .QW (DIV_QW),
      .SW (HSW)
   ) u_hue_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p3_valid_ff),
      .dividend  (p3_hnum_ff),
      .divisor   (p3_diff_ff),
      .side_in   (HSW'(p3_side_ff)),
      .out_valid (hue_dv_valid),
      .quotient  (hue_q),
      .side_out  (hue_side_bits)
   );

   // A zero max only occurs for black; flag it so saturation can be forced.
   hwpm_div #(
      .DW (DIV_DW),
      .QW (DIV_QW),
      .SW (1)
   ) u_sat_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p3_valid_ff),
      .dividend  (p3_snum_ff),
      .divisor   (p3_side_ff.max_val),
      .side_in   (p3_side_ff.max_val == '0),
      .out_valid (sat_dv_valid),
      .quotient  (sat_q),
      .side_out  (sat_side_bits)
   );

   assign dv_side = hue_side_type'(hue_side_bits);

   // ------------------------------------------------------------------
   // Stage 12: assemble hue and saturation
   // ------------------------------------------------------------------
   logic             p4_valid_ff;
   req_type          p4_pix_ff;
   logic [HUE_W-1:0] p4_hue_ff, p4_hue_in;
   logic [PIX_W-1:0] p4_sat_ff, p4_sat_in;
   logic [PIX_W-1:0] p4_val_ff;

   always_comb begin
      logic [10:0] ofs, qx, hsum;
      case (dv_side.sector)
         SECTOR_RED:   ofs = HUE_OFS_RED;
         SECTOR_GREEN: ofs = HUE_OFS_GREEN;
         SECTOR_BLUE:  ofs = HUE_OFS_BLUE;
         default:      ofs = HUE_OFS_RED;
      endcase
      qx   = 11'(hue_q);
      hsum = dv_side.neg ? (ofs - qx) : (ofs + qx);
      // Wrap a negative hue (red sector, blue above green) into range.
      if (hsum[10]) begin
         hsum = hsum + HUE_FULL;
      end
      p4_hue_in = dv_side.grey ? '0 : hsum[HUE_W-1:0];
      p4_sat_in = sat_side_bits[0] ? '0 : sat_q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else begin
         p4_valid_ff <= hue_dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      p4_pix_ff <= dv_side.pixel;
      p4_hue_ff <= p4_hue_in;
      p4_sat_ff <= p4_sat_in;
      p4_val_ff <= dv_side.max_val;
   end

   // ------------------------------------------------------------------
   // Stage 13: window compare, gate the pixel, drive the response
   // ------------------------------------------------------------------
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      logic [CSR_W-1:0] sat_x, val_x;
      logic             pass;
      sat_x = CSR_W'(p4_sat_ff);
      val_x = CSR_W'(p4_val_ff);
      pass  = (hue_low_ff < p4_hue_ff) && (p4_hue_ff < hue_high_ff) &&
              (sat_low_ff < sat_x)     && (sat_x < sat_high_ff) &&
              (val_low_ff < val_x)     && (val_x < val_high_ff);
      rsp_data_in.red_out    = pass ? p4_pix_ff.red_in   : '0;
      rsp_data_in.green_out  = pass ? p4_pix_ff.green_in : '0;
      rsp_data_in.blue_out   = pass ? p4_pix_ff.blue_in  : '0;
      rsp_data_in.in_region  = pass;
      rsp_data_in.hue        = p4_hue_ff;
      rsp_data_in.saturation = p4_sat_ff;
      rsp_data_in.brightness = p4_val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= p4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   `HWPM_ASSERT_IMPL(a_div_lockstep_hs, clock, reset, hue_dv_valid, sat_dv_valid)
   `HWPM_ASSERT_IMPL(a_div_lockstep_sh, clock, reset, sat_dv_valid, hue_dv_valid)
   `HWPM_ASSERT_NEXT(a_hue_range, clock, reset, p4_valid_ff, rsp_data.hue < 9'd360)
   `HWPM_ASSERT_IMPL(a_masked_black, clock, reset, rsp_valid && !rsp_data.in_region, rsp_data.red_out == 8'd0 && rsp_data.green_out == 8'd0 && rsp_data.blue_out == 8'd0)

endmodule

@@ hdl/hwpm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module hwpm_div
   import hwpm_pkg::*;
#(
   parameter int DW = DIV_DW,
   parameter int QW = DIV_QW,
   parameter int SW = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [DW+QW-1:0]    dividend,
   input  logic [DW-1:0]       divisor,
   input  logic [SW-1:0]       side_in,
   output logic                out_valid,
   output logic [QW-1:0]       quotient,
   output logic [SW-1:0]       side_out
);

   localparam int NW = DW + QW;

   // Caller guarantees dividend[NW-1:QW] < divisor, so the quotient fits QW bits.
   wire [DW-1:0] rem_w [0:QW];
   wire [QW-1:0] lo_w  [0:QW];
   wire [QW-1:0] q_w   [0:QW];
   wire [DW-1:0] dv_w  [0:QW];
   wire [SW-1:0] sd_w  [0:QW];
   wire          vl_w  [0:QW];

   assign rem_w[0] = dividend[NW-1:QW];
   assign lo_w[0]  = dividend[QW-1:0];
   assign q_w[0]   = '0;
   assign dv_w[0]  = divisor;
   assign sd_w[0]  = side_in;
   assign vl_w[0]  = in_valid;

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;
      logic [QW-1:0] qbit;
      logic          vl_ff;
      logic [DW-1:0] rem_ff;
      logic [QW-1:0] lo_ff;
      logic [QW-1:0] q_ff;
      logic [DW-1:0] dv_ff;
      logic [SW-1:0] sd_ff;

      assign trial = {rem_w[k], lo_w[k][QW-1-k]};
      assign diff  = trial - {1'b0, dv_w[k]};
      assign ge    = (trial >= {1'b0, dv_w[k]});
      assign qbit  = {{(QW-1){1'b0}}, ge} << (QW-1-k);

      always_ff @(posedge clock) begin
         if (reset) begin
            vl_ff <= 1'b0;
         end else begin
            vl_ff <= vl_w[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff <= ge ? diff[DW-1:0] : trial[DW-1:0];
         lo_ff  <= lo_w[k];
         q_ff   <= q_w[k] | qbit;
         dv_ff  <= dv_w[k];
         sd_ff  <= sd_w[k];
      end

      assign rem_w[k+1] = rem_ff;
      assign lo_w[k+1]  = lo_ff;
      assign q_w[k+1]   = q_ff;
      assign dv_w[k+1]  = dv_ff;
      assign sd_w[k+1]  = sd_ff;
      assign vl_w[k+1]  = vl_ff;
   end

   assign out_valid = vl_w[QW];
   assign quotient  = q_w[QW];
   assign side_out  = sd_w[QW];

endmodule
